>>> hdl/assert_macros.svh
// Assertion helpers for the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every rising clock edge outside of reset.
`define SVA_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked from one edge to the next.
`define SVA_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SVA_ALWAYS(lbl, clk, rst, prop, msg)
`define SVA_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/sbs_pkg.sv
`timescale 1ns / 1ps
package sbs_pkg;
   localparam int DIGIT_W = 4;
   localparam int CMD_W   = 2;
   localparam int COORD_W = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic STATUS_SOLVED = 1'b0;
   localparam logic STATUS_NONE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_PEER,
      ST_PICK,
      ST_BACK,
      ST_BACK_CHK
   } state_type;
endpackage

>>> hdl/sbs_if.sv
`timescale 1ns / 1ps
interface sbs_req_if;
   logic                      valid;
   logic                      ready;
   logic [sbs_pkg::CMD_W-1:0]   command;
   logic [sbs_pkg::COORD_W-1:0] row_index;
   logic [sbs_pkg::COORD_W-1:0] col_index;
   logic [sbs_pkg::DIGIT_W-1:0] cell_value;
   modport source (output valid, command, row_index, col_index, cell_value, input ready);
   modport sink (input valid, command, row_index, col_index, cell_value, output ready);
endinterface

interface sbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbs_pkg::DIGIT_W-1:0] read_value;
   logic                        status;
   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
endinterface

>>> hdl/sbs_ram.sv
`timescale 1ns / 1ps
module sbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hdl/sudoku_backtracking_solver_unit.sv
`timescale 1ns / 1ps
// Sudoku solver with a depth-first backtracking search.
// The req channel carries load, solve and read transactions; the rsp channel
// returns one transaction for each solve (status) and each read (read_value).
// A load returns nothing. A read value passes through the registered read
// port of the grid memory and then the rsp register. A solve is data dependent:
// every trial cell costs one scan of its 3*SIDE peers through the single read
// port of the grid memory, and each cell skipped or passed while stepping back
// costs one more read of it.
// The block takes no new transaction while a solve or read is in progress.
// A result waits in the rsp register; while it is not taken the block still
// accepts a transaction in the same cycle that the waiting result leaves.
// Reset clears the grid and the given marks at once through per-cell valid
// bits; there is no clearing pass.
module sudoku_backtracking_solver_unit #(
   parameter int BOX_SIZE = 3
) (
   input  logic clock,
   input  logic reset,
   sbs_req_if.sink   req_chan,
   sbs_rsp_if.source rsp_chan
);
   import sbs_pkg::*;
   `include "assert_macros.svh"

   localparam int SIDE   = BOX_SIZE * BOX_SIZE;
   localparam int NCELLS = SIDE * SIDE;
   localparam int PEERS  = 3 * SIDE;
   localparam int CELL_W = $clog2(NCELLS);
   localparam int CUR_W  = $clog2(NCELLS + 1);
   localparam int PEER_W = $clog2(PEERS + 1);

   state_type state_ff, state_in;
   logic [CUR_W-1:0]   cursor_ff, cursor_in;
   logic [DIGIT_W-1:0] cand_ff, cand_in;
   logic [SIDE-1:0]    mask_ff, mask_in;
   logic [PEER_W-1:0]  peer_ff, peer_in;
   logic               acc_ff, acc_in;
   logic               inside_ff, inside_in;
   logic               sel_valid_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [NCELLS-1:0]  cell_valid_ff;

   logic                 wr_en;
   logic [CELL_W-1:0]    wr_addr, rd_addr;
   logic [DIGIT_W:0]     wr_data, rd_data;
   logic [DIGIT_W-1:0]   cell_digit;
   logic                 cell_given;
   logic                 req_inside;
   logic [CELL_W-1:0]    req_idx;
   logic [CELL_W-1:0]    cur_cell, cur_row, cur_col, box_row, box_col, peer_addr;

   // Quotient by a constant through a row of parallel compares.
   function automatic logic [CUR_W-1:0] quot_const(logic [CUR_W-1:0] value, int divisor,
                                                    int limit);
      logic [CUR_W-1:0] q;
      q = '0;
      for (int k = 1; k <= limit; k++) begin
         if (int'(value) >= k * divisor) q = CUR_W'(k);
      end
      return q;
   endfunction

   sbs_ram #(.WIDTH(DIGIT_W + 1), .DEPTH(NCELLS)) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A cell never written since reset reads as empty and not given.
   assign cell_digit = sel_valid_ff ? rd_data[DIGIT_W-1:0] : '0;
   assign cell_given = sel_valid_ff & rd_data[DIGIT_W];

   assign req_inside = (req_chan.row_index < SIDE) && (req_chan.col_index < SIDE);
   assign req_idx    = CELL_W'(req_chan.row_index * SIDE + req_chan.col_index);

   assign cur_cell = cursor_ff[CELL_W-1:0];
   assign cur_row  = CELL_W'(quot_const(cursor_ff, SIDE, SIDE));
   assign cur_col  = CELL_W'(int'(cursor_ff) - int'(cur_row) * SIDE);
   assign box_row  = CELL_W'(int'(quot_const(CUR_W'(cur_row), BOX_SIZE, BOX_SIZE)) * BOX_SIZE);
   assign box_col  = CELL_W'(int'(quot_const(CUR_W'(cur_col), BOX_SIZE, BOX_SIZE)) * BOX_SIZE);

   // Peers in order: the row, then the column, then the box.
   always_comb begin
      logic [PEER_W-1:0] j;
      logic [CUR_W-1:0]  jq;
      j  = '0;
      jq = '0;
      if (peer_ff < SIDE) begin
         peer_addr = CELL_W'(cur_row * SIDE + peer_ff);
      end else if (peer_ff < 2 * SIDE) begin
         peer_addr = CELL_W'((peer_ff - SIDE) * SIDE + cur_col);
      end else begin
         j  = PEER_W'(peer_ff - 2 * SIDE);
         jq = quot_const(CUR_W'(j), BOX_SIZE, BOX_SIZE);
         peer_addr = CELL_W'((int'(box_row) + int'(jq)) * SIDE + int'(box_col) +
                             int'(j) - int'(jq) * BOX_SIZE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= '0;
         cand_ff       <= '0;
         peer_ff       <= '0;
         acc_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cell_valid_ff <= '0;
         sel_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         cand_ff      <= cand_in;
         peer_ff      <= peer_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_valid_ff <= cell_valid_ff[rd_addr];
         if (wr_en) begin
            cell_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      inside_ff     <= inside_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic found;
      logic [DIGIT_W-1:0] pick;
      found         = 1'b0;
      pick          = '0;
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      cand_in       = cand_ff;
      mask_in       = mask_ff;
      peer_in       = peer_ff;
      acc_in        = 1'b0;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_cell;
      wr_data       = '0;
      rd_addr       = cur_cell;
      req_chan.ready = 1'b0;

      // Fold in the peer digit read in the previous cycle.
      if (acc_ff && cell_digit != 0 && cell_digit <= SIDE) begin
         mask_in = mask_ff | (SIDE'(1) << (cell_digit - 1'b1));
      end

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
            if (req_chan.valid && req_chan.ready) begin
               case (req_chan.command)
                  CMD_LOAD: begin
                     if (req_inside) begin
                        wr_en   = 1'b1;
                        wr_addr = req_idx;
                        wr_data = {req_chan.cell_value != 0, req_chan.cell_value};
                     end
                  end
                  CMD_SOLVE: begin
                     cursor_in = '0;
                     state_in  = ST_SCAN_RD;
                  end
                  CMD_READ: begin
                     rd_addr   = req_inside ? req_idx : '0;
                     inside_in = req_inside;
                     state_in  = ST_READ_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = inside_ff ? cell_digit : '0;
            rsp_status_in = STATUS_SOLVED;
            state_in      = ST_IDLE;
         end
         ST_SCAN_RD: begin
            if (cursor_ff == NCELLS) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_SOLVED;
               cand_in       = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (cell_digit != 0) begin
               cursor_in = CUR_W'(cursor_ff + 1'b1);
               state_in  = ST_SCAN_RD;
            end else begin
               cand_in  = DIGIT_W'(1);
               peer_in  = '0;
               mask_in  = '0;
               state_in = ST_PEER;
            end
         end
         ST_PEER: begin
            if (peer_ff < PEERS) begin
               rd_addr = peer_addr;
               peer_in = PEER_W'(peer_ff + 1'b1);
               acc_in  = 1'b1;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            for (int d = SIDE; d >= 1; d--) begin
               if (DIGIT_W'(d) >= cand_ff && !mask_ff[d-1]) begin
                  found = 1'b1;
                  pick  = DIGIT_W'(d);
               end
            end
            if (found) begin
               wr_en     = 1'b1;
               wr_data   = {1'b0, pick};
               cand_in   = pick;
               cursor_in = CUR_W'(cursor_ff + 1'b1);
               state_in  = ST_SCAN_RD;
            end else begin
               state_in = ST_BACK;
            end
         end
         ST_BACK: begin
            if (cursor_ff == 0) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_NONE;
               cand_in       = '0;
               state_in      = ST_IDLE;
            end else begin
               cursor_in = CUR_W'(cursor_ff - 1'b1);
               rd_addr   = CELL_W'(cursor_ff - 1'b1);
               state_in  = ST_BACK_CHK;
            end
         end
         ST_BACK_CHK: begin
            if (cell_given) begin
               state_in = ST_BACK;
            end else begin
               wr_en   = 1'b1;
               wr_data = '0;
               if (cell_digit >= DIGIT_W'(SIDE)) begin
                  state_in = ST_BACK;
               end else begin
                  cand_in  = DIGIT_W'(cell_digit + 1'b1);
                  peer_in  = '0;
                  mask_in  = '0;
                  state_in = ST_PEER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   `SVA_ALWAYS(a_ready_idle, clock, reset, !req_chan.ready || state_ff == ST_IDLE,
      "ready raised outside idle")
   `SVA_ALWAYS(a_cursor_range, clock, reset, cursor_ff <= NCELLS, "cursor past grid")
   `SVA_ALWAYS(a_peer_range, clock, reset, state_ff != ST_PEER || peer_ff <= PEERS,
      "peer counter overran")
   `SVA_NEXT(a_read_resp, clock, reset, state_ff == ST_READ_WAIT,
      rsp_valid_ff && state_ff == ST_IDLE, "read result not presented")
endmodule
